@@ design/ppd_pkg.sv @@
// Shared constants and types for the point-to-plane distance unit.
// Used by ppd_mul and point_plane_distance_3d_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

   // Width of the distance field of a result word.
   localparam int DIST_BITS = 30;

   // Operand chunk width of the pipelined multiplier.
   localparam int CHUNK_BITS = 24;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_INVALID    = 2'd1;
   localparam status_type ST_DEGENERATE = 2'd2;

endpackage

`default_nettype wire

@@ design/point_plane_distance_3d_unit.sv @@
// Point-to-plane distance unit: top level with the full stage pipeline.
// Depends on ppd_pkg and ppd_mul.
//
// Usage: each req word carries plane points a, b, c and query point q as
// twelve signed coordinates; each rsp word returns the unsigned distance
// |n.(q-b)|/|n| with FRAC_BITS fraction bits, truncated, where n is the
// cross product (a-b)x(b-c). Status travels on rsp_tuser: ok, invalid point
// (one point is the origin, distance 0) or degenerate plane (zero normal,
// distance 0).
// Throughput is one word per cycle while the output is not stalled: nine
// arithmetic stages (differences, cross product, magnitudes, two pipelined
// multipliers, sums) are followed by one stage per distance bit, each a
// shift-add-compare step of the square-root-quotient search.
// The whole pipeline advances together; when the receiver stalls with a
// word waiting at the output, every stage holds and req_tready drops, so
// nothing is lost or repeated. Reset clears all valid bits; no result is
// presented until a new word has passed through.
`timescale 1ns / 1ps
`default_nettype none

module point_plane_distance_3d_unit #(
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z
   input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // distance
   output logic [((ppd_pkg::DIST_BITS+7)/8)*8-1:0]     rsp_tdata,
   // status
   output ppd_pkg::status_type                         rsp_tuser
);

   localparam int CB    = COORD_BITS;
   localparam int DW    = CB + 1;
   localparam int PW    = 2 * DW;
   localparam int NW    = PW + 1;
   localparam int MW    = DW;
   localparam int TW    = NW + MW;
   localparam int DOTW  = TW + 2;
   localparam int NNW   = 2 * NW + 2;
   localparam int RW    = 2 * DOTW + 2 * FRAC_BITS;
   localparam int DB    = ppd_pkg::DIST_BITS;
   localparam int SW    = ((RW > NNW + 2 * DB) ? RW : NNW + 2 * DB) + 2;
   localparam int LAT   = 9 + DB;
   localparam int OUT_W = ((DB + 7) / 8) * 8;

   logic           en;
   logic [LAT-1:0] vld_ff;

   // Pipeline control: all stages move when the output is free or taken.
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Stage 1: edge vectors, query offset and the origin check.
   logic signed [CB-1:0] pt [4][3];
   logic signed [DW-1:0] s0_in [3], s1_in [3], m_in [3];
   logic signed [DW-1:0] s0_ff [3], s1_ff [3], m1_ff [3];
   logic                 inv_in, inv1_ff;

   always_comb begin
      inv_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            pt[k][i] = req_tdata[(k*3+i)*CB +: CB];
         end
         if (pt[k][0] == '0 && pt[k][1] == '0 && pt[k][2] == '0) begin
            inv_in = 1'b1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         s0_in[i] = DW'(pt[0][i]) - DW'(pt[1][i]);
         s1_in[i] = DW'(pt[1][i]) - DW'(pt[2][i]);
         m_in[i]  = DW'(pt[3][i]) - DW'(pt[1][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         m1_ff   <= m_in;
         inv1_ff <= inv_in;
      end
   end

   // Stage 2: the six products of the cross product.
   logic signed [PW-1:0] prod_ff [6];
   logic signed [DW-1:0] m2_ff [3];
   logic                 inv2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PW'(s0_ff[1]) * PW'(s1_ff[2]);
         prod_ff[1] <= PW'(s0_ff[2]) * PW'(s1_ff[1]);
         prod_ff[2] <= PW'(s0_ff[2]) * PW'(s1_ff[0]);
         prod_ff[3] <= PW'(s0_ff[0]) * PW'(s1_ff[2]);
         prod_ff[4] <= PW'(s0_ff[0]) * PW'(s1_ff[1]);
         prod_ff[5] <= PW'(s0_ff[1]) * PW'(s1_ff[0]);
         m2_ff      <= m1_ff;
         inv2_ff    <= inv1_ff;
      end
   end

   // Stage 3: normal components, magnitudes and term signs.
   logic signed [NW-1:0] n_in [3];
   logic [NW-1:0]        nmag_in [3], nmag_ff [3];
   logic [MW-1:0]        mmag_in [3], mmag_ff [3];
   logic [2:0]           sgn_in, sgn3_ff, sgn4_ff, sgn5_ff;
   logic                 inv3_ff, inv4_ff, inv5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i]    = NW'(prod_ff[2*i]) - NW'(prod_ff[2*i+1]);
         nmag_in[i] = n_in[i][NW-1] ? NW'(-n_in[i]) : NW'(n_in[i]);
         mmag_in[i] = m2_ff[i][MW-1] ? MW'(-m2_ff[i]) : MW'(m2_ff[i]);
         sgn_in[i]  = n_in[i][NW-1] ^ m2_ff[i][MW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= nmag_in;
         mmag_ff <= mmag_in;
         sgn3_ff <= sgn_in;
         inv3_ff <= inv2_ff;
         sgn4_ff <= sgn3_ff;
         sgn5_ff <= sgn4_ff;
         inv4_ff <= inv3_ff;
         inv5_ff <= inv4_ff;
      end
   end

   // Stages 4 and 5: normal-offset products and squared normal components.
   logic [TW-1:0]   nm_prod [3];
   logic [2*NW-1:0] nn_prod [3];

   for (genvar i = 0; i < 3; i++) begin : g_mul
      ppd_mul #(.A_W(NW), .B_W(MW)) u_nm (
         .clock (clock),
         .en    (en),
         .a     (nmag_ff[i]),
         .b     (mmag_ff[i]),
         .p     (nm_prod[i])
      );
      ppd_mul #(.A_W(NW), .B_W(NW)) u_nn (
         .clock (clock),
         .en    (en),
         .a     (nmag_ff[i]),
         .b     (nmag_ff[i]),
         .p     (nn_prod[i])
      );
   end

   // Stage 6: positive and negative dot product parts and the squared norm.
   logic [DOTW-1:0] pos_in, neg_in, pos_ff, neg_ff;
   logic [NNW-1:0]  nn_in, nn6_ff;
   logic            inv6_ff;

   always_comb begin
      pos_in = '0;
      neg_in = '0;
      nn_in  = '0;
      for (int i = 0; i < 3; i++) begin
         if (sgn5_ff[i]) begin
            neg_in = neg_in + DOTW'(nm_prod[i]);
         end else begin
            pos_in = pos_in + DOTW'(nm_prod[i]);
         end
         nn_in = nn_in + NNW'(nn_prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff  <= pos_in;
         neg_ff  <= neg_in;
         nn6_ff  <= nn_in;
         inv6_ff <= inv5_ff;
      end
   end

   // Stage 7: absolute dot product and the zero-normal check.
   logic [DOTW-1:0] dot_ff;
   logic [NNW-1:0]  nn7_ff, nn8_ff, nn9_ff;
   logic            inv7_ff, inv8_ff, inv9_ff;
   logic            deg7_ff, deg8_ff, deg9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff  <= (pos_ff >= neg_ff) ? pos_ff - neg_ff : neg_ff - pos_ff;
         nn7_ff  <= nn6_ff;
         deg7_ff <= (nn6_ff == '0);
         inv7_ff <= inv6_ff;
         nn8_ff  <= nn7_ff;
         nn9_ff  <= nn8_ff;
         deg8_ff <= deg7_ff;
         deg9_ff <= deg8_ff;
         inv8_ff <= inv7_ff;
         inv9_ff <= inv8_ff;
      end
   end

   // Stages 8 and 9: square of the dot product.
   logic [2*DOTW-1:0] dot_sq;

   ppd_mul #(.A_W(DOTW), .B_W(DOTW)) u_dot_sq (
      .clock (clock),
      .en    (en),
      .a     (dot_ff),
      .b     (dot_ff),
      .p     (dot_sq)
   );

   // Search stages: one distance bit each, from the top bit down. The
   // residual e = dot^2*2^(2F) - d^2*nn and the product p = d*nn are kept,
   // so trying a bit needs only shifts, one add and one compare.
   logic [SW-1:0]  e_src [DB], p_src [DB], e_ff [DB], p_ff [DB];
   logic [DB-1:0]  d_src [DB], d_ff [DB];
   logic [NNW-1:0] nn_src [DB], nns_ff [DB];
   logic           inv_src [DB], deg_src [DB], invs_ff [DB], degs_ff [DB];

   for (genvar k = 0; k < DB; k++) begin : g_search
      localparam int BIT = DB - 1 - k;

      logic [SW-1:0] t_in;
      logic          fit_in;

      if (k == 0) begin : g_first
         assign e_src[k]   = SW'(dot_sq) << (2 * FRAC_BITS);
         assign p_src[k]   = '0;
         assign d_src[k]   = '0;
         assign nn_src[k]  = nn9_ff;
         assign inv_src[k] = inv9_ff;
         assign deg_src[k] = deg9_ff;
      end else begin : g_next
         assign e_src[k]   = e_ff[k-1];
         assign p_src[k]   = p_ff[k-1];
         assign d_src[k]   = d_ff[k-1];
         assign nn_src[k]  = nns_ff[k-1];
         assign inv_src[k] = invs_ff[k-1];
         assign deg_src[k] = degs_ff[k-1];
      end

      assign t_in   = (p_src[k] << (BIT + 1)) + (SW'(nn_src[k]) << (2 * BIT));
      assign fit_in = (t_in <= e_src[k]);

      always_ff @(posedge clock) begin
         if (en) begin
            e_ff[k]    <= fit_in ? e_src[k] - t_in : e_src[k];
            p_ff[k]    <= fit_in ? p_src[k] + (SW'(nn_src[k]) << BIT) : p_src[k];
            d_ff[k]    <= d_src[k] | (DB'(fit_in) << BIT);
            nns_ff[k]  <= nn_src[k];
            invs_ff[k] <= inv_src[k];
            degs_ff[k] <= deg_src[k];
         end
      end
   end

   // Output word: special cases force the distance to zero.
   always_comb begin
      rsp_tdata = '0;
      if (invs_ff[DB-1]) begin
         rsp_tuser = ppd_pkg::ST_INVALID;
      end else if (degs_ff[DB-1]) begin
         rsp_tuser = ppd_pkg::ST_DEGENERATE;
      end else begin
         rsp_tuser = ppd_pkg::ST_OK;
         rsp_tdata = OUT_W'(d_ff[DB-1]);
      end
   end

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ppd_pkg::ST_OK |-> rsp_tdata[DB-1:0] == '0)
      else $error("nonzero distance with a special status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ppd_pkg::ST_OK || rsp_tuser == ppd_pkg::ST_INVALID
                      || rsp_tuser == ppd_pkg::ST_DEGENERATE))
      else $error("undefined status code on a result word");
`endif

endmodule

`default_nettype wire

@@ design/ppd_mul.sv @@
// Two-stage unsigned multiplier built from chunk partial products.
// Uses ppd_pkg for the chunk width; instantiated by point_plane_distance_3d_unit.
`timescale 1ns / 1ps
`default_nettype none

module ppd_mul #(
   parameter int A_W = 43,
   parameter int B_W = 21
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic      [A_W+B_W-1:0] p
);

   localparam int CW   = ppd_pkg::CHUNK_BITS;
   localparam int NA   = (A_W + CW - 1) / CW;
   localparam int NB   = (B_W + CW - 1) / CW;
   localparam int SUMW = (NA + NB) * CW;

   logic [NA*CW-1:0]   a_pad;
   logic [NB*CW-1:0]   b_pad;
   logic [2*CW-1:0]    pp_ff [NA*NB];
   logic [SUMW-1:0]    sum_in;
   logic [A_W+B_W-1:0] p_ff;

   assign a_pad = (NA*CW)'(a);
   assign b_pad = (NB*CW)'(b);

   // First stage: every chunk pair is multiplied and registered.
   for (genvar i = 0; i < NA; i++) begin : g_a
      for (genvar j = 0; j < NB; j++) begin : g_b
         always_ff @(posedge clock) begin
            if (en) begin
               pp_ff[i*NB+j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
            end
         end
      end
   end

   // Second stage: the shifted partial products are summed.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SUMW'(pp_ff[i*NB+j]) << ((i + j) * CW));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum_in[A_W+B_W-1:0];
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

@@ sim/point_plane_distance_3d_unit_tb.sv @@
// Self-checking testbench for the point-to-plane distance unit.
// Depends on ppd_pkg and point_plane_distance_3d_unit; drives stream words with random
// idling on both sides and checks every result against an exact integer predictor.
`timescale 1ns / 1ps

module point_plane_distance_3d_unit_tb;

   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 8;
   localparam int DIST_BITS  = ppd_pkg::DIST_BITS;
   localparam int REQ_BITS   = ((12*COORD_BITS+7)/8)*8;
   localparam int RSP_BITS   = ((DIST_BITS+7)/8)*8;
   localparam int LATENCY    = 39;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   // Order: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z.
   typedef coord_type points_type [12];

   typedef struct {
      logic [DIST_BITS-1:0] distance;
      ppd_pkg::status_type  status;
   } distance_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   ppd_pkg::status_type rsp_tuser;

   distance_type pending_distances[$];
   int           error_count;
   int           send_idle_pct;
   int           recv_idle_pct;

   point_plane_distance_3d_unit #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Exact distance: the largest D with D^2 * |n|^2 <= (n.m)^2 * 2^(2*FRAC_BITS).
   function automatic distance_type plane_distance(input points_type p);
      distance_type           r;
      logic signed [127:0]    pt [12];
      logic signed [127:0]    s0 [3];
      logic signed [127:0]    s1 [3];
      logic signed [127:0]    mv [3];
      logic signed [127:0]    nv [3];
      logic signed [127:0]    dot;
      logic [255:0]           dot_mag;
      logic [255:0]           norm_sq;
      logic [255:0]           scaled;
      logic [255:0]           cand;
      logic [DIST_BITS-1:0]   dist_acc;
      r.distance = '0;
      r.status   = ppd_pkg::ST_OK;
      for (int i = 0; i < 12; i++) pt[i] = p[i];
      // A point at the origin marks a missing point and wins over everything else.
      for (int k = 0; k < 4; k++) begin
         if (pt[3*k] == 0 && pt[3*k+1] == 0 && pt[3*k+2] == 0) begin
            r.status = ppd_pkg::ST_INVALID;
            return r;
         end
      end
      for (int i = 0; i < 3; i++) begin
         s0[i] = pt[i] - pt[3+i];
         s1[i] = pt[3+i] - pt[6+i];
         mv[i] = pt[9+i] - pt[3+i];
      end
      nv[0] = s0[1]*s1[2] - s0[2]*s1[1];
      nv[1] = s0[2]*s1[0] - s0[0]*s1[2];
      nv[2] = s0[0]*s1[1] - s0[1]*s1[0];
      norm_sq = '0;
      dot     = 0;
      for (int i = 0; i < 3; i++) begin
         norm_sq = norm_sq + 256'(nv[i]*nv[i]);
         dot     = dot + nv[i]*mv[i];
      end
      // A zero normal means the three plane points are collinear.
      if (norm_sq == 0) begin
         r.status = ppd_pkg::ST_DEGENERATE;
         return r;
      end
      dot_mag  = (dot < 0) ? 256'(-dot) : 256'(dot);
      scaled   = (dot_mag * dot_mag) << (2*FRAC_BITS);
      dist_acc = '0;
      for (int b = DIST_BITS-1; b >= 0; b--) begin
         cand = 256'(dist_acc | (30'd1 << b));
         if (cand * cand * norm_sq <= scaled) dist_acc = cand[DIST_BITS-1:0];
      end
      r.distance = dist_acc;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Send one word, with random idle cycles ahead of it, and record its expected result.
   task automatic send_points(input points_type p);
      logic [REQ_BITS-1:0] word;
      word = '0;
      for (int i = 0; i < 12; i++) word[i*COORD_BITS +: COORD_BITS] = p[i];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_distances.push_back(plane_distance(p));
   endtask

   // Receiver side idling.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      distance_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pending_distances.pop_front();
            if (rsp_tdata[DIST_BITS-1:0] !== want.distance)
               report_mismatch("distance", rsp_tdata[DIST_BITS-1:0], want.distance);
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
         end
      end
   end

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   function automatic coord_type rand_small(input int span);
      return coord_type'($urandom_range(2*span) - span);
   endfunction

   function automatic points_type make_points(input int ax, ay, az, bx, by, bz,
                                              cx, cy, cz, qx, qy, qz);
      points_type p;
      p = '{coord_type'(ax), coord_type'(ay), coord_type'(az), coord_type'(bx),
            coord_type'(by), coord_type'(bz), coord_type'(cx), coord_type'(cy),
            coord_type'(cz), coord_type'(qx), coord_type'(qy), coord_type'(qz)};
      return p;
   endfunction

   // Field extremes and simple planes with known distances.
   task automatic test_extremes();
      localparam int MAXC = (1 << (COORD_BITS-1)) - 1;
      localparam int MINC = -(1 << (COORD_BITS-1));
      send_points(make_points(1, 0, 0, 0, 1, 0, 0, 0, 1, 5, 5, 5));
      send_points(make_points(1, 0, 7, 0, 1, 7, 3, 3, 7, 2, 9, -4));
      send_points(make_points(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC,
                              MINC, MAXC, MINC));
      send_points(make_points(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC, MAXC, MAXC, MAXC));
      send_points(make_points(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, MINC, MINC, MINC));
      send_points(make_points(MAXC, 1, 0, MINC, 0, 1, 1, MINC, MAXC, 0, MAXC, MINC));
      send_points(make_points(-1, -1, -1, 1, 1, 1, -1, 1, -1, 1, -1, 1));
      send_points(make_points(5, 0, 3, 0, 5, 3, 2, 2, 3, 9, 1, 3));
   endtask

   // Origin marker on each point, collinear planes, and both together.
   task automatic test_special_cases();
      send_points(make_points(0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9));
      send_points(make_points(1, 2, 3, 0, 0, 0, 4, 5, 7, 7, 8, 9));
      send_points(make_points(1, 2, 3, 4, 5, 7, 0, 0, 0, 7, 8, 9));
      send_points(make_points(1, 2, 3, 4, 5, 7, 2, 9, 1, 0, 0, 0));
      send_points(make_points(0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3));
      send_points(make_points(1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 0, 9));
      send_points(make_points(7, -3, 2, 7, -3, 2, 7, -3, 2, 1, 1, 1));
      send_points(make_points(4, 5, 6, 4, 5, 6, 1, 9, 2, 3, 3, 3));
      send_points(make_points(3, 6, 9, 1, 2, 3, -1, -2, -3, 100, -7, 2));
   endtask

   // Random words: mostly general planes, some small, collinear or with a missing point.
   task automatic test_random(input int count);
      points_type p;
      int         kind, k1, k2;
      coord_type  d [3];
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         for (int i = 0; i < 12; i++) p[i] = rand_coord();
         if (kind < 25) begin
            for (int i = 0; i < 12; i++) p[i] = rand_small(200);
         end else if (kind < 37) begin
            k1 = $urandom_range(8) - 4;
            k2 = $urandom_range(8) - 4;
            for (int i = 0; i < 3; i++) begin
               d[i]   = rand_small(3000);
               p[3+i] = rand_small(100000);
               p[i]   = coord_type'(p[3+i] + k1 * d[i]);
               p[6+i] = coord_type'(p[3+i] + k2 * d[i]);
            end
         end else if (kind < 45) begin
            k1 = $urandom_range(3);
            for (int i = 0; i < 3; i++) p[3*k1+i] = '0;
         end else if (kind < 50) begin
            // Query point on the plane through a, b and c: equal to one of them.
            k1 = $urandom_range(2);
            for (int i = 0; i < 3; i++) p[9+i] = p[3*k1+i];
         end
         send_points(p);
      end
   endtask

   initial begin
      error_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 62;
      test_extremes();
      test_special_cases();
      test_random(400);
      send_idle_pct = 62;
      recv_idle_pct = 26;
      test_random(410);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(420);
      req_tvalid <= 1'b0;

      while (pending_distances.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
